// ===== sv/fdr_pkg.sv =====
// shared types, codes and constants for the fixed frame receiver
package fdr_pkg;

    localparam int FRAME_LEN_DEFAULT = 10;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int REPORT_LEN = 10;

    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_REPORT = 2'd1;
    localparam logic [1:0] ACT_ACK = 2'd2;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_MULTIPLE = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_STOP = 3'd1;
    localparam logic [2:0] REG_TYPE_UPDATE = 3'd2;
    localparam logic [2:0] REG_TYPE_SINGLE = 3'd3;
    localparam logic [2:0] REG_TYPE_MULTIPLE = 3'd4;
    localparam logic [2:0] REG_TYPE_ACK = 3'd5;
    localparam logic [2:0] REG_TYPE_REPORT = 3'd6;

    localparam logic [7:0] START_RESET = 8'd126;
    localparam logic [7:0] STOP_RESET = 8'd127;
    localparam logic [7:0] TYPE_UPDATE_RESET = 8'd1;
    localparam logic [7:0] TYPE_SINGLE_RESET = 8'd2;
    localparam logic [7:0] TYPE_MULTIPLE_RESET = 8'd3;
    localparam logic [7:0] TYPE_ACK_RESET = 8'd4;
    localparam logic [7:0] TYPE_REPORT_RESET = 8'd5;

    localparam logic [7:0] ASCII_ONE = 8'h31;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] stop_byte;
        logic [7:0] type_update;
        logic [7:0] type_single;
        logic [7:0] type_multiple;
        logic [7:0] type_ack;
        logic [7:0] type_report;
    } cfg_t;

    typedef struct packed {
        logic        is_report;
        logic [1:0]  kind;
        logic [7:0]  sensor_index;
        logic [7:0]  value;
        logic [7:0]  report_count;
        logic [15:0] bad_count;
        logic [15:0] good_count;
        logic        ack;
        logic        led;
    } cmd_t;

endpackage

// ===== sv/fdr_front.sv =====
// front end: frame assembly, checking, counters and dispatch decode
module fdr_front #(
    parameter int FRAME_LEN = fdr_pkg::FRAME_LEN_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    action,
    input  logic [7:0]    rx_byte,
    input  logic          ack_value,
    input  fdr_pkg::cfg_t cfg,
    output logic          cmd_valid,
    output fdr_pkg::cmd_t cmd
);
    import fdr_pkg::*;

    localparam int IW = $clog2(FRAME_LEN);
    localparam logic [IW-1:0] LAST_POS = IW'(FRAME_LEN - 1);
    localparam logic [IW-1:0] TYPE_POS = IW'(1);
    localparam logic [IW-1:0] SENSOR_POS = IW'(3);
    localparam logic [IW-1:0] ARG_POS = IW'(4);

    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0]   good_reg, good_next;
    logic [15:0]   bad_reg, bad_next;
    logic [7:0]    rc_reg, rc_next;
    logic          ack_reg, ack_next;
    logic          led_reg, led_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    sensor_reg, sensor_next;
    logic [7:0]    arg_reg, arg_next;
    logic [7:0]    mapped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            good_reg <= '0;
            bad_reg <= '0;
            rc_reg <= '0;
            ack_reg <= 1'b0;
            led_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            good_reg <= good_next;
            bad_reg <= bad_next;
            rc_reg <= rc_next;
            ack_reg <= ack_next;
            led_reg <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        sensor_reg <= sensor_next;
        arg_reg <= arg_next;
    end

    // ascii digit one to nine maps to sensor zero to eight
    assign mapped = (sensor_reg >= ASCII_ONE && sensor_reg <= ASCII_NINE)
                  ? sensor_reg - ASCII_ONE : sensor_reg;

    always_comb
    begin
        idx_next = idx_reg;
        good_next = good_reg;
        bad_next = bad_reg;
        rc_next = rc_reg;
        ack_next = ack_reg;
        led_next = led_reg;
        type_next = type_reg;
        sensor_next = sensor_reg;
        arg_next = arg_reg;
        cmd_valid = 1'b0;
        cmd = '0;
        if (in_valid)
        begin
            case (action)
                ACT_BYTE:
                begin
                    if (rx_byte == cfg.start_byte)
                    begin
                        led_next = 1'b1;
                        idx_next = IW'(1);
                    end
                    else if (idx_reg < LAST_POS)
                    begin
                        if (idx_reg == TYPE_POS)
                            type_next = rx_byte;
                        if (idx_reg == SENSOR_POS)
                            sensor_next = rx_byte;
                        if (idx_reg == ARG_POS)
                            arg_next = rx_byte;
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        if (rx_byte == cfg.stop_byte)
                        begin
                            led_next = 1'b0;
                            good_next = good_reg + 16'd1;
                            if (type_reg == cfg.type_update)
                            begin
                                cmd_valid = 1'b0;
                            end
                            else if (type_reg == cfg.type_single)
                            begin
                                cmd_valid = 1'b1;
                                cmd.kind = KIND_SINGLE;
                                cmd.sensor_index = sensor_reg;
                            end
                            else if (type_reg == cfg.type_multiple)
                            begin
                                cmd_valid = 1'b1;
                                cmd.kind = KIND_MULTIPLE;
                                cmd.sensor_index = mapped;
                                cmd.value = arg_reg;
                            end
                            else if (type_reg == cfg.type_ack)
                            begin
                                ack_next = 1'b1;
                            end
                        end
                        else
                        begin
                            bad_next = bad_reg + 16'd1;
                        end
                        idx_next = '0;
                    end
                end
                ACT_REPORT:
                begin
                    rc_next = rc_reg + 8'd1;
                    cmd_valid = 1'b1;
                    cmd.is_report = 1'b1;
                    cmd.kind = KIND_REPORT;
                    cmd.report_count = rc_next;
                    cmd.bad_count = bad_reg;
                    cmd.good_count = good_reg;
                    good_next = '0;
                    bad_next = '0;
                end
                ACT_ACK:
                begin
                    ack_next = ack_value;
                end
                default:
                begin
                    idx_next = idx_reg;
                end
            endcase
        end
        cmd.ack = ack_next;
        cmd.led = led_next;
    end

endmodule

// ===== sv/fdr_queue.sv =====
// short command queue between front and back
module fdr_queue #(
    parameter int DEPTH = fdr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fdr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output fdr_pkg::cmd_t head,
    output logic          head_valid
);
    import fdr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

// ===== sv/fdr_back.sv =====
// back end: result generation, report serializer and output register
module fdr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  fdr_pkg::cfg_t cfg,
    input  logic          head_valid,
    input  fdr_pkg::cmd_t head,
    output logic          head_pop,
    output logic          empty,
    input  logic          pop,
    output logic [1:0]    out_kind,
    output logic [7:0]    sensor_index,
    output logic [7:0]    out_value,
    output logic          last,
    output logic          ack_flag,
    output logic          frame_led
);
    import fdr_pkg::*;

    localparam int BW = $clog2(REPORT_LEN);
    localparam logic [BW-1:0] LAST_BEAT = BW'(REPORT_LEN - 1);

    logic          ovalid_reg, ovalid_next;
    logic [BW-1:0] beat_reg, beat_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    sensor_reg, sensor_next;
    logic [7:0]    value_reg, value_next;
    logic          last_reg, last_next;
    logic          ack_reg, ack_next;
    logic          led_reg, led_next;
    logic          load;
    logic [7:0]    report_byte;

    assign load = !ovalid_reg || pop;

    always_comb
    begin
        case (beat_reg)
            BW'(0): report_byte = cfg.start_byte;
            BW'(1): report_byte = cfg.type_report;
            BW'(2): report_byte = head.report_count;
            BW'(5): report_byte = head.bad_count[15:8];
            BW'(6): report_byte = head.bad_count[7:0];
            BW'(7): report_byte = head.good_count[15:8];
            BW'(8): report_byte = head.good_count[7:0];
            BW'(9): report_byte = cfg.stop_byte;
            default: report_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        beat_next = beat_reg;
        kind_next = kind_reg;
        sensor_next = sensor_reg;
        value_next = value_reg;
        last_next = last_reg;
        ack_next = ack_reg;
        led_next = led_reg;
        head_pop = 1'b0;
        if (load)
        begin
            ovalid_next = head_valid;
            if (head_valid)
            begin
                kind_next = head.kind;
                ack_next = head.ack;
                led_next = head.led;
                if (head.is_report)
                begin
                    sensor_next = 8'd0;
                    value_next = report_byte;
                    last_next = (beat_reg == LAST_BEAT);
                    head_pop = (beat_reg == LAST_BEAT);
                    beat_next = (beat_reg == LAST_BEAT) ? '0 : beat_reg + 1'b1;
                end
                else
                begin
                    sensor_next = head.sensor_index;
                    value_next = head.value;
                    last_next = 1'b1;
                    head_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            beat_reg <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        sensor_reg <= sensor_next;
        value_reg <= value_next;
        last_reg <= last_next;
        ack_reg <= ack_next;
        led_reg <= led_next;
    end

    assign empty = !ovalid_reg;
    assign out_kind = kind_reg;
    assign sensor_index = sensor_reg;
    assign out_value = value_reg;
    assign last = last_reg;
    assign ack_flag = ack_reg;
    assign frame_led = led_reg;

endmodule

// ===== sv/fixed_frame_receiver_dispatch.sv =====
// top level of the fixed frame receiver with request dispatch and status report
//
// channel   direction  handshake              payload
// input     in         push / full            action, rx_byte, ack_value
// result    out        empty / pop            out_kind, sensor_index, out_value, last,
//                                             ack_flag, frame_led
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one input item per cycle while full is low; a byte or ack item finishes in the front end
// a good single or multiple frame gives one result, a report tick gives ten, one per cycle
// while pop is held, from the serializer in the back end; each result passes the command
// queue and the output register; full rises when the command queue between front and back is full
// reset clears counters, frame position, flags and queue; config registers take defaults
module fixed_frame_receiver_dispatch #(
    parameter int FRAME_LEN = fdr_pkg::FRAME_LEN_DEFAULT,
    parameter int QUEUE_DEPTH = fdr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] action,
    input  logic [7:0] rx_byte,
    input  logic       ack_value,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] out_kind,
    output logic [7:0] sensor_index,
    output logic [7:0] out_value,
    output logic       last,
    output logic       ack_flag,
    output logic       frame_led,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import fdr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic in_accept;
    logic cmd_valid;
    cmd_t cmd;
    cmd_t head;
    logic head_valid;
    logic head_pop;

    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START:         cfg_next.start_byte = cfg_data;
                REG_STOP:          cfg_next.stop_byte = cfg_data;
                REG_TYPE_UPDATE:   cfg_next.type_update = cfg_data;
                REG_TYPE_SINGLE:   cfg_next.type_single = cfg_data;
                REG_TYPE_MULTIPLE: cfg_next.type_multiple = cfg_data;
                REG_TYPE_ACK:      cfg_next.type_ack = cfg_data;
                REG_TYPE_REPORT:   cfg_next.type_report = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte <= START_RESET;
            cfg_reg.stop_byte <= STOP_RESET;
            cfg_reg.type_update <= TYPE_UPDATE_RESET;
            cfg_reg.type_single <= TYPE_SINGLE_RESET;
            cfg_reg.type_multiple <= TYPE_MULTIPLE_RESET;
            cfg_reg.type_ack <= TYPE_ACK_RESET;
            cfg_reg.type_report <= TYPE_REPORT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fdr_front #(
        .FRAME_LEN(FRAME_LEN)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_accept),
        .action(action),
        .rx_byte(rx_byte),
        .ack_value(ack_value),
        .cfg(cfg_reg),
        .cmd_valid(cmd_valid),
        .cmd(cmd)
    );

    fdr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(cmd_valid),
        .push_cmd(cmd),
        .full(full),
        .pop(head_pop),
        .head(head),
        .head_valid(head_valid)
    );

    fdr_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .head_valid(head_valid),
        .head(head),
        .head_pop(head_pop),
        .empty(empty),
        .pop(pop),
        .out_kind(out_kind),
        .sensor_index(sensor_index),
        .out_value(out_value),
        .last(last),
        .ack_flag(ack_flag),
        .frame_led(frame_led)
    );

`ifndef SYNTHESIS
    // report beats follow one another with no gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> !empty)
    else $error("report frame broken off");

    // request results are single items
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != KIND_REPORT) |-> last)
    else $error("request result without last");

    // a non-final result is always a report byte with no sensor
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> (out_kind == KIND_REPORT && sensor_index == 8'd0))
    else $error("bad report beat");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the fixed frame receiver with request dispatch
module tb_top;
    import fdr_pkg::*;

    localparam int FRAME_LEN = FRAME_LEN_DEFAULT;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] sensor;
        logic [7:0] value;
        logic       last;
        logic       ack;
        logic       led;
    } result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] action = ACT_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic       ack_value = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] out_kind;
    logic [7:0] sensor_index;
    logic [7:0] out_value;
    logic       last;
    logic       ack_flag;
    logic       frame_led;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = REG_START;
    logic [7:0] cfg_data = 8'h00;

    cfg_t rx_cfg = '{START_RESET, STOP_RESET, TYPE_UPDATE_RESET, TYPE_SINGLE_RESET,
                     TYPE_MULTIPLE_RESET, TYPE_ACK_RESET, TYPE_REPORT_RESET};
    logic [7:0]  frame_store [FRAME_LEN];
    int          write_pos = 0;
    logic [15:0] good_frames = '0;
    logic [15:0] bad_frames = '0;
    logic [7:0]  reports_sent = '0;
    logic        ack_state = 1'b0;
    logic        led_state = 1'b0;

    result_t dispatch_q [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    fixed_frame_receiver_dispatch u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .rx_byte      (rx_byte),
        .ack_value    (ack_value),
        .empty        (empty),
        .pop          (pop),
        .out_kind     (out_kind),
        .sensor_index (sensor_index),
        .out_value    (out_value),
        .last         (last),
        .ack_flag     (ack_flag),
        .frame_led    (frame_led),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic add_result(input logic [1:0] kind, input logic [7:0] sensor,
                              input logic [7:0] value, input logic is_last);
        result_t r;
        r.kind = kind;
        r.sensor = sensor;
        r.value = value;
        r.last = is_last;
        r.ack = ack_state;
        r.led = led_state;
        dispatch_q.push_back(r);
    endtask

    task automatic parse_item(input logic [1:0] act, input logic [7:0] b, input logic ackv);
        logic [7:0] ftype;
        logic [7:0] sel;
        logic [7:0] report [REPORT_LEN];
        case (act)
            ACT_BYTE:
            begin
                if (b == rx_cfg.start_byte)
                begin
                    led_state = 1'b1;
                    frame_store[0] = b;
                    write_pos = 1;
                end
                else if (write_pos < FRAME_LEN - 1)
                begin
                    frame_store[write_pos] = b;
                    write_pos++;
                end
                else
                begin
                    if (b == rx_cfg.stop_byte)
                    begin
                        ftype = frame_store[1];
                        sel = frame_store[3];
                        led_state = 1'b0;
                        good_frames++;
                        if (ftype != rx_cfg.type_update)
                        begin
                            if (ftype == rx_cfg.type_single)
                                add_result(KIND_SINGLE, sel, 8'h00, 1'b1);
                            else if (ftype == rx_cfg.type_multiple)
                            begin
                                if (sel >= ASCII_ONE && sel <= ASCII_NINE)
                                    sel = sel - ASCII_ONE;
                                add_result(KIND_MULTIPLE, sel, frame_store[4], 1'b1);
                            end
                            else if (ftype == rx_cfg.type_ack)
                                ack_state = 1'b1;
                        end
                    end
                    else
                        bad_frames++;
                    write_pos = 0;
                end
            end
            ACT_REPORT:
            begin
                reports_sent++;
                report = '{rx_cfg.start_byte, rx_cfg.type_report, reports_sent, 8'h00, 8'h00,
                           bad_frames[15:8], bad_frames[7:0], good_frames[15:8],
                           good_frames[7:0], rx_cfg.stop_byte};
                for (int k = 0; k < REPORT_LEN; k++)
                    add_result(KIND_REPORT, 8'h00, report[k], k == REPORT_LEN - 1);
                bad_frames = '0;
                good_frames = '0;
            end
            ACT_ACK:
                ack_state = ackv;
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (dispatch_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0h value %0h",
                         $time, out_kind, out_value);
                mismatches++;
            end
            else
            begin
                want = dispatch_q.pop_front();
                check_field("out_kind", 8'(want.kind), 8'(out_kind));
                check_field("sensor_index", want.sensor, sensor_index);
                check_field("out_value", want.value, out_value);
                check_field("last", 8'(want.last), 8'(last));
                check_field("ack_flag", 8'(want.ack), 8'(ack_flag));
                check_field("frame_led", 8'(want.led), 8'(frame_led));
            end
        end
    end

    initial
    begin : watchdog
        int quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("fixed_frame_receiver_dispatch verification failed");
        $finish;
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] b, input logic ackv);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        action <= act;
        rx_byte <= b;
        ack_value <= ackv;
        do
            @(posedge clk);
        while (full);
        parse_item(act, b, ackv);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(ACT_BYTE, b, 1'($urandom_range(1)));
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == rx_cfg.start_byte);
        return b;
    endfunction

    task automatic send_frame(input bit good_stop);
        logic [7:0] ftype;
        logic [7:0] sel;
        logic [7:0] tail;
        case ($urandom_range(5))
            0: ftype = rx_cfg.type_update;
            1: ftype = rx_cfg.type_single;
            2, 3: ftype = rx_cfg.type_multiple;
            4: ftype = rx_cfg.type_ack;
            default: ftype = 8'($urandom_range(255));
        endcase
        case ($urandom_range(5))
            0: sel = ASCII_ONE;
            1: sel = ASCII_NINE;
            2: sel = ASCII_ONE - 8'd1;
            3: sel = ASCII_NINE + 8'd1;
            4: sel = ASCII_ONE + 8'($urandom_range(8));
            default: sel = 8'($urandom_range(255));
        endcase
        // aborted partial frame, restarted by a fresh start byte
        if ($urandom_range(9) == 0)
        begin
            send_byte(rx_cfg.start_byte);
            repeat ($urandom_range(1, FRAME_LEN - 2))
                send_byte(body_byte());
        end
        send_byte(rx_cfg.start_byte);
        send_byte(ftype);
        send_byte(body_byte());
        send_byte(sel);
        send_byte(8'($urandom_range(255)));
        repeat (FRAME_LEN - 6)
            send_byte(body_byte());
        tail = rx_cfg.stop_byte;
        if (!good_stop)
        begin
            do
                tail = 8'($urandom_range(255));
            while (tail == rx_cfg.stop_byte);
        end
        send_byte(tail);
    endtask

    task automatic quiesce();
        @(negedge clk);
        push <= 1'b0;
        while (dispatch_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_START: rx_cfg.start_byte = data;
            REG_STOP: rx_cfg.stop_byte = data;
            REG_TYPE_UPDATE: rx_cfg.type_update = data;
            REG_TYPE_SINGLE: rx_cfg.type_single = data;
            REG_TYPE_MULTIPLE: rx_cfg.type_multiple = data;
            REG_TYPE_ACK: rx_cfg.type_ack = data;
            REG_TYPE_REPORT: rx_cfg.type_report = data;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        quiesce();
        write_reg(REG_START, c.start_byte);
        write_reg(REG_STOP, c.stop_byte);
        write_reg(REG_TYPE_UPDATE, c.type_update);
        write_reg(REG_TYPE_SINGLE, c.type_single);
        write_reg(REG_TYPE_MULTIPLE, c.type_multiple);
        write_reg(REG_TYPE_ACK, c.type_ack);
        write_reg(REG_TYPE_REPORT, c.type_report);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t rand_config();
        cfg_t c;
        logic [7:0] base;
        c.start_byte = 8'($urandom_range(255));
        c.stop_byte = 8'($urandom_range(255));
        do
            base = 8'($urandom_range(255));
        while (8'(c.start_byte - base) < 8'd4);
        c.type_update = base;
        c.type_single = base + 8'd1;
        c.type_multiple = base + 8'd2;
        c.type_ack = base + 8'd3;
        c.type_report = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic run_frames(input int count);
        repeat (count)
            send_frame($urandom_range(4) != 0);
        send_item(ACT_REPORT, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic test_reset_directed();
        logic [7:0] seq [$];
        send_idle_pct = 26;
        recv_idle_pct = 52;
        send_item(ACT_UNUSED, 8'hFF, 1'b1);
        send_item(ACT_ACK, 8'h00, 1'b1);
        send_item(ACT_ACK, 8'hFF, 1'b0);
        send_item(ACT_REPORT, 8'h00, 1'b0);
        // frame with no start byte ahead of it, then a restart at the last position
        seq = '{8'h00, TYPE_SINGLE_RESET, 8'h80, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
                STOP_RESET,
                START_RESET, TYPE_MULTIPLE_RESET, 8'h01, ASCII_ONE, 8'hFF, 8'h02, 8'h03,
                8'h04, 8'h05, START_RESET,
                TYPE_MULTIPLE_RESET, 8'h00, ASCII_NINE, 8'h00, 8'h10, 8'h20, 8'h40, 8'h80,
                STOP_RESET};
        foreach (seq[i])
            send_byte(seq[i]);
        send_item(ACT_REPORT, 8'hFF, 1'b1);
    endtask

    task automatic test_config_extremes();
        load_config('{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h00});
        run_frames(3);
        load_config('{8'hFF, 8'h00, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'hFF});
        run_frames(3);
    endtask

    task automatic test_overlapping_codes();
        load_config('{8'h7E, 8'h7F, 8'h20, 8'h10, 8'h10, 8'h20, 8'h05});
        run_frames(3);
        load_config('{8'h55, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04, 8'hAA});
        run_frames(2);
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        int target;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        load_config(rand_config());
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame($urandom_range(6) != 0);
            else if (pick < 80)
                send_item(ACT_REPORT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (pick < 90)
                send_item(ACT_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_directed();
        test_config_extremes();
        test_overlapping_codes();
        test_random(26, 52, 72);
        test_random(52, 26, 72);
        test_random(0, 0, 72);
        quiesce();
        if (mismatches == 0 && dispatch_q.size() == 0)
            $display("fixed_frame_receiver_dispatch verification clean");
        else
            $display("fixed_frame_receiver_dispatch verification failed");
        $finish;
    end

endmodule
